// ===== sv/t2b_pkg.sv =====
// Shared types and constants for the text to binary64 converter.
// Used by the parser front end, the record queue and the conversion back end.
`default_nettype none

package t2b_pkg;

    localparam int MANT_W = 96;
    localparam int END_W  = 17;

    // Number kinds reported with each result.
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_DEC  = 3'd1;
    localparam logic [2:0] KIND_HEX  = 3'd2;
    localparam logic [2:0] KIND_INF  = 3'd3;
    localparam logic [2:0] KIND_NAN  = 3'd4;

    // Rounding mode codes.
    localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
    localparam logic [2:0] RM_ZERO      = 3'd1;
    localparam logic [2:0] RM_DOWN      = 3'd2;
    localparam logic [2:0] RM_UP        = 3'd3;
    localparam logic [2:0] RM_NEAR_AWAY = 3'd4;

    // One parsed number, handed from the parser to the converter.
    typedef struct packed {
        logic                neg;
        logic [2:0]          kind;
        logic [MANT_W-1:0]   mant;
        logic signed [17:0]  impl_exp;
        logic [13:0]         expl_exp;
        logic                exp_neg;
        logic                sticky;
        logic [END_W-1:0]    end_off;
    } num_rec_t;

    // Undefined mode codes behave as nearest even.
    function automatic logic [2:0] eff_mode(input logic [2:0] mode);
        eff_mode = (mode > RM_NEAR_AWAY) ? RM_NEAR_EVEN : mode;
    endfunction

endpackage

`default_nettype wire

// ===== sv/t2b_queue.sv =====
// Two-entry queue of parsed number records between parser and converter.
// Depends on t2b_pkg for the record type.
`default_nettype none

module t2b_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire t2b_pkg::num_rec_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output t2b_pkg::num_rec_t      head,
    output logic                   not_empty
);

    t2b_pkg::num_rec_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage is payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/t2b_front.sv =====
// Character parser: takes one byte per cycle while s_ready is high and builds a number record.
// Depends on t2b_pkg for kinds, rounding codes and the record type.
`default_nettype none

module t2b_front #(
    parameter int MAX_CHARS  = 4096,
    parameter int DEC_DIGITS = 28
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    input  wire logic              s_last,
    input  wire logic [2:0]        mode,
    output logic                   push,
    input  wire logic              q_full,
    output t2b_pkg::num_rec_t      rec
);

    localparam int CW = $clog2(MAX_CHARS + 2);
    localparam int HEX_DIGITS = t2b_pkg::MANT_W / 4;
    localparam logic signed [18:0] IMPL_SAT = 19'sd131071;
    localparam logic [16:0] EXPL_SAT = 17'd8191;

    localparam logic [3:0] PH_WS       = 4'd0;
    localparam logic [3:0] PH_LEAD     = 4'd1;
    localparam logic [3:0] PH_INF      = 4'd2;
    localparam logic [3:0] PH_INF_TAIL = 4'd3;
    localparam logic [3:0] PH_NAN      = 4'd4;
    localparam logic [3:0] PH_NAN_OPEN = 4'd5;
    localparam logic [3:0] PH_NAN_TAG  = 4'd6;
    localparam logic [3:0] PH_ZERO     = 4'd7;
    localparam logic [3:0] PH_HEX_X    = 4'd8;
    localparam logic [3:0] PH_HEX_DOT  = 4'd9;
    localparam logic [3:0] PH_DOT_1ST  = 4'd10;
    localparam logic [3:0] PH_MANT     = 4'd11;
    localparam logic [3:0] PH_EXP_MARK = 4'd12;
    localparam logic [3:0] PH_EXP_SIGN = 4'd13;
    localparam logic [3:0] PH_EXP_DIG  = 4'd14;
    localparam logic [3:0] PH_DONE     = 4'd15;

    function automatic logic [7:0] inf_char(input logic [2:0] idx);
        case (idx)
            3'd0:    inf_char = "i";
            3'd1:    inf_char = "n";
            default: inf_char = "f";
        endcase
    endfunction

    function automatic logic [7:0] inity_char(input logic [2:0] idx);
        case (idx)
            3'd0:    inity_char = "i";
            3'd1:    inity_char = "n";
            3'd2:    inity_char = "i";
            3'd3:    inity_char = "t";
            default: inity_char = "y";
        endcase
    endfunction

    function automatic logic [7:0] nan_char(input logic [2:0] idx);
        case (idx)
            3'd0:    nan_char = "n";
            3'd1:    nan_char = "a";
            default: nan_char = "n";
        endcase
    endfunction

    logic [3:0]               phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic                     hex_reg, hex_next;
    logic                     pt_reg, pt_next;
    logic [t2b_pkg::MANT_W-1:0] mant_reg, mant_next;
    logic [4:0]               dcnt_reg, dcnt_next;
    logic signed [17:0]       impl_reg, impl_next;
    logic [13:0]              expl_reg, expl_next;
    logic                     eneg_reg, eneg_next;
    logic                     sticky_reg, sticky_next;
    logic                     rno_reg, rno_next;
    logic [CW-1:0]            ccount_reg, ccount_next;
    logic [CW-1:0]            cend_reg, cend_next;
    logic [2:0]               wmi_reg, wmi_next;
    logic [2:0]               kind_reg, kind_next;
    logic                     flush_reg, flush_next;

    logic acc_in, flush_go, feed_go;
    logic [t2b_pkg::MANT_W-1:0] mant_x10, mant_x16, mant_p1;

    // Feed results, before the end-of-string clear.
    logic [3:0]               f_phase;
    logic                     f_neg, f_hex, f_pt, f_eneg, f_sticky, f_rno;
    logic [t2b_pkg::MANT_W-1:0] f_mant;
    logic [4:0]               f_dcnt;
    logic signed [17:0]       f_impl;
    logic [13:0]              f_expl;
    logic [CW-1:0]            f_ccount, f_cend;
    logic [2:0]               f_wmi, f_kind;

    assign s_ready  = !flush_reg;
    assign acc_in   = s_valid && s_ready;
    assign flush_go = flush_reg && !q_full;
    assign feed_go  = (phase_reg != PH_DONE) && (acc_in || flush_go);
    assign push     = flush_go;

    // Digit accumulation candidates.
    always_comb begin
        mant_x10 = {mant_reg[t2b_pkg::MANT_W-4:0], 3'b000}
                 + {mant_reg[t2b_pkg::MANT_W-2:0], 1'b0};
        mant_x16 = {mant_reg[t2b_pkg::MANT_W-5:0], 4'b0000};
        mant_p1  = mant_reg + t2b_pkg::MANT_W'(1);
    end

    // One character step of the parser.
    always_comb begin
        logic [7:0]  c, l;
        logic        dec_c, hex_c;
        logic [3:0]  hv;
        logic        do_dig, do_bump, do_commit, rn, skip, away;
        logic [3:0]  dv;
        logic signed [3:0]  bump_d;
        logic signed [18:0] bump_t;
        logic [16:0] ex_t;
        logic [2:0]  m;

        c = (flush_reg || (ccount_reg >= CW'(MAX_CHARS))) ? 8'd0 : s_char_code;
        l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        dec_c = (c >= "0") && (c <= "9");
        hex_c = dec_c || ((l >= "a") && (l <= "f"));
        hv = dec_c ? c[3:0] : (l[3:0] + 4'd9);
        m = t2b_pkg::eff_mode(mode);
        do_dig = 1'b0;
        do_bump = 1'b0;
        do_commit = 1'b0;
        dv = 4'd0;
        bump_d = 4'sd0;
        rn = rno_reg;
        skip = 1'b0;
        away = 1'b0;
        bump_t = 19'sd0;
        ex_t = (17'(expl_reg) << 3) + (17'(expl_reg) << 1) + 17'(c[3:0]);

        f_phase  = phase_reg;
        f_neg    = neg_reg;
        f_hex    = hex_reg;
        f_pt     = pt_reg;
        f_mant   = mant_reg;
        f_dcnt   = dcnt_reg;
        f_impl   = impl_reg;
        f_expl   = expl_reg;
        f_eneg   = eneg_reg;
        f_sticky = sticky_reg;
        f_rno    = rno_reg;
        f_ccount = ccount_reg;
        f_cend   = cend_reg;
        f_wmi    = wmi_reg;
        f_kind   = kind_reg;

        if (feed_go) begin
            f_ccount = ccount_reg + CW'(1);
            // Whitespace and sign are taken only at the start; the rest is shared with the sign phase.
            if (phase_reg == PH_WS && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                f_phase = PH_WS;
            end else if (phase_reg == PH_WS && c == "+") begin
                f_phase = PH_LEAD;
            end else if (phase_reg == PH_WS && c == "-") begin
                f_neg = 1'b1;
                f_phase = PH_LEAD;
            end else if (phase_reg == PH_WS || phase_reg == PH_LEAD) begin
                if (l == "i") begin
                    f_phase = PH_INF;
                    f_wmi = 3'd1;
                end else if (l == "n") begin
                    f_phase = PH_NAN;
                    f_wmi = 3'd1;
                end else if (c == "0") begin
                    f_phase = PH_ZERO;
                    f_kind = t2b_pkg::KIND_DEC;
                    do_commit = 1'b1;
                end else if (dec_c) begin
                    f_phase = PH_MANT;
                    f_kind = t2b_pkg::KIND_DEC;
                    do_dig = 1'b1;
                    dv = c[3:0];
                    do_commit = 1'b1;
                end else if (c == ".") begin
                    f_phase = PH_DOT_1ST;
                end else begin
                    f_phase = PH_DONE;
                end
            end else begin
                unique case (phase_reg)
                    PH_INF: begin
                        if (wmi_reg < 3'd3 && l == inf_char(wmi_reg)) begin
                            f_wmi = wmi_reg + 3'd1;
                            if (wmi_reg == 3'd2) begin
                                f_kind = t2b_pkg::KIND_INF;
                                do_commit = 1'b1;
                                f_phase = PH_INF_TAIL;
                                f_wmi = 3'd0;
                            end
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_INF_TAIL: begin
                        if (wmi_reg < 3'd5 && l == inity_char(wmi_reg)) begin
                            f_wmi = wmi_reg + 3'd1;
                            if (wmi_reg == 3'd4) begin
                                do_commit = 1'b1;
                                f_phase = PH_DONE;
                            end
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_NAN: begin
                        if (wmi_reg < 3'd3 && l == nan_char(wmi_reg)) begin
                            f_wmi = wmi_reg + 3'd1;
                            if (wmi_reg == 3'd2) begin
                                f_kind = t2b_pkg::KIND_NAN;
                                do_commit = 1'b1;
                                f_phase = PH_NAN_OPEN;
                            end
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_NAN_OPEN: begin
                        f_phase = (c == "(") ? PH_NAN_TAG : PH_DONE;
                    end
                    PH_NAN_TAG: begin
                        if (!(dec_c || (l >= "a" && l <= "z") || c == "_")) begin
                            do_commit = (c == ")");
                            f_phase = PH_DONE;
                        end
                    end
                    PH_HEX_X, PH_HEX_DOT: begin
                        if (hex_c) begin
                            f_hex = 1'b1;
                            f_kind = t2b_pkg::KIND_HEX;
                            if (phase_reg == PH_HEX_DOT) begin
                                f_pt = 1'b1;
                            end
                            f_phase = PH_MANT;
                            do_dig = 1'b1;
                            dv = hv;
                            do_commit = 1'b1;
                        end else if (c == "." && phase_reg == PH_HEX_X) begin
                            f_phase = PH_HEX_DOT;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_DOT_1ST: begin
                        if (dec_c) begin
                            f_pt = 1'b1;
                            f_kind = t2b_pkg::KIND_DEC;
                            f_phase = PH_MANT;
                            do_dig = 1'b1;
                            dv = c[3:0];
                            do_commit = 1'b1;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_ZERO, PH_MANT: begin
                        if (phase_reg == PH_ZERO && l == "x") begin
                            f_phase = PH_HEX_X;
                        end else if (hex_reg ? hex_c : dec_c) begin
                            f_phase = PH_MANT;
                            do_dig = 1'b1;
                            dv = hex_reg ? hv : c[3:0];
                            do_commit = 1'b1;
                        end else if (c == ".") begin
                            if (pt_reg) begin
                                f_phase = PH_DONE;
                            end else begin
                                f_phase = PH_MANT;
                                f_pt = 1'b1;
                                do_commit = 1'b1;
                            end
                        end else if (l == (hex_reg ? 8'("p") : 8'("e"))) begin
                            f_phase = PH_EXP_MARK;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    PH_EXP_MARK, PH_EXP_SIGN, PH_EXP_DIG: begin
                        if (dec_c) begin
                            f_expl = (ex_t > EXPL_SAT) ? 14'(EXPL_SAT) : ex_t[13:0];
                            do_commit = 1'b1;
                            f_phase = PH_EXP_DIG;
                        end else if (phase_reg == PH_EXP_MARK && (c == "+" || c == "-")) begin
                            f_eneg = (c == "-");
                            f_phase = PH_EXP_SIGN;
                        end else begin
                            f_phase = PH_DONE;
                        end
                    end
                    default: begin
                        f_phase = PH_DONE;
                    end
                endcase
            end

            // Significant digit handling.
            if (do_dig) begin
                if (dcnt_reg == 5'd0 && dv == 4'd0) begin
                    if (f_pt) begin
                        do_bump = 1'b1;
                        bump_d = f_hex ? -4'sd4 : -4'sd1;
                    end
                end else if (f_hex) begin
                    if (dcnt_reg < 5'(HEX_DIGITS)) begin
                        f_mant = mant_x16 | t2b_pkg::MANT_W'(dv);
                        f_dcnt = dcnt_reg + 5'd1;
                        do_bump = f_pt;
                        bump_d = -4'sd4;
                    end else begin
                        if (dv != 4'd0) begin
                            f_sticky = 1'b1;
                        end
                        do_bump = !f_pt;
                        bump_d = 4'sd4;
                    end
                end else if (dcnt_reg < 5'(DEC_DIGITS)) begin
                    f_mant = mant_x10 + t2b_pkg::MANT_W'(dv);
                    f_dcnt = dcnt_reg + 5'd1;
                    do_bump = f_pt;
                    bump_d = -4'sd1;
                end else begin
                    do_bump = !f_pt;
                    bump_d = 4'sd1;
                    away = (m == t2b_pkg::RM_UP && !f_neg)
                        || (m == t2b_pkg::RM_DOWN && f_neg);
                    // The first dropped digit decides how later digits round.
                    if (dcnt_reg == 5'(DEC_DIGITS)) begin
                        f_dcnt = dcnt_reg + 5'd1;
                        if (m == t2b_pkg::RM_NEAR_EVEN) begin
                            rn = (dv >= 4'd5);
                            skip = 1'b1;
                        end else if (m == t2b_pkg::RM_NEAR_AWAY) begin
                            if (dv >= 4'd5) begin
                                f_mant = mant_p1;
                            end
                        end else if (away) begin
                            rn = 1'b1;
                        end
                    end
                    if (!skip && rn && dv != 4'd0) begin
                        f_mant = mant_p1;
                        rn = 1'b0;
                    end
                    f_rno = rn;
                end
            end

            // Saturating implicit exponent.
            if (do_bump) begin
                bump_t = 19'(impl_reg) + 19'(bump_d);
                if (bump_t > IMPL_SAT) begin
                    f_impl = 18'(IMPL_SAT);
                end else if (bump_t < -IMPL_SAT) begin
                    f_impl = 18'(-IMPL_SAT);
                end else begin
                    f_impl = bump_t[17:0];
                end
            end

            if (do_commit) begin
                f_cend = f_ccount;
            end
        end
    end

    // Next state: accepted byte, end-of-string clear, or hold.
    always_comb begin
        if (flush_go) begin
            phase_next  = PH_WS;
            neg_next    = 1'b0;
            hex_next    = 1'b0;
            pt_next     = 1'b0;
            mant_next   = '0;
            dcnt_next   = 5'd0;
            impl_next   = 18'sd0;
            expl_next   = 14'd0;
            eneg_next   = 1'b0;
            sticky_next = 1'b0;
            rno_next    = 1'b0;
            ccount_next = '0;
            cend_next   = '0;
            wmi_next    = 3'd0;
            kind_next   = t2b_pkg::KIND_NONE;
            flush_next  = 1'b0;
        end else begin
            phase_next  = f_phase;
            neg_next    = f_neg;
            hex_next    = f_hex;
            pt_next     = f_pt;
            mant_next   = f_mant;
            dcnt_next   = f_dcnt;
            impl_next   = f_impl;
            expl_next   = f_expl;
            eneg_next   = f_eneg;
            sticky_next = f_sticky;
            rno_next    = f_rno;
            ccount_next = f_ccount;
            cend_next   = f_cend;
            wmi_next    = f_wmi;
            kind_next   = f_kind;
            flush_next  = flush_reg || (acc_in && s_last);
        end
    end

    // Record of the finished number, taken at the end-of-string step.
    always_comb begin
        rec.neg      = f_neg;
        rec.kind     = f_kind;
        rec.mant     = f_mant;
        rec.impl_exp = f_impl;
        rec.expl_exp = f_expl;
        rec.exp_neg  = f_eneg;
        rec.sticky   = f_sticky;
        rec.end_off  = (f_kind != t2b_pkg::KIND_NONE) ? t2b_pkg::END_W'(f_cend) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WS;
            neg_reg    <= 1'b0;
            hex_reg    <= 1'b0;
            pt_reg     <= 1'b0;
            mant_reg   <= '0;
            dcnt_reg   <= 5'd0;
            impl_reg   <= 18'sd0;
            expl_reg   <= 14'd0;
            eneg_reg   <= 1'b0;
            sticky_reg <= 1'b0;
            rno_reg    <= 1'b0;
            ccount_reg <= '0;
            cend_reg   <= '0;
            wmi_reg    <= 3'd0;
            kind_reg   <= t2b_pkg::KIND_NONE;
            flush_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            hex_reg    <= hex_next;
            pt_reg     <= pt_next;
            mant_reg   <= mant_next;
            dcnt_reg   <= dcnt_next;
            impl_reg   <= impl_next;
            expl_reg   <= expl_next;
            eneg_reg   <= eneg_next;
            sticky_reg <= sticky_next;
            rno_reg    <= rno_next;
            ccount_reg <= ccount_next;
            cend_reg   <= cend_next;
            wmi_reg    <= wmi_next;
            kind_reg   <= kind_next;
            flush_reg  <= flush_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/t2b_back.sv =====
// Converter: scales a parsed number, rounds it and packs binary64 results.
// Depends on t2b_pkg for kinds, rounding codes and the record type.
`default_nettype none

module t2b_back #(
    parameter int OUT_W = 13
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire t2b_pkg::num_rec_t head,
    output logic                   pop,
    input  wire logic [2:0]        mode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [63:0]            m_value_bits,
    output logic [OUT_W-1:0]       m_end_offset,
    output logic                   m_range_error,
    output logic [2:0]             m_number_kind
);

    localparam int MW = t2b_pkg::MANT_W;
    localparam int DIV_W = 24;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PNORM = 3'd3;
    localparam logic [2:0] ST_PSUB  = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_PACK  = 3'd6;
    localparam logic [4:0] DIV_LAST = 5'(MW / DIV_W - 1);
    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
    localparam logic signed [15:0] MIN_EXP = -16'sd1022;

    logic [2:0]          state_reg, state_next;
    logic [MW-1:0]       acc_reg, acc_next;
    logic signed [13:0]  e_reg, e_next;
    logic signed [15:0]  y_reg, y_next;
    logic [3:0]          rem_reg, rem_next;
    logic [4:0]          dcnt_reg, dcnt_next;
    logic                neg_reg, neg_next;
    logic [2:0]          kind_reg, kind_next;
    logic                zero_reg, zero_next;
    logic                trunc_reg, trunc_next;
    logic                sub_reg, sub_next;
    logic [OUT_W-1:0]    end_reg, end_next;

    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_bits_reg, m_bits_next;
    logic [OUT_W-1:0]    m_end_reg, m_end_next;
    logic                m_rerr_reg, m_rerr_next;
    logic [2:0]          m_kind_reg, m_kind_next;

    logic                out_free;

    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_value_bits  = m_bits_reg;
    assign m_end_offset  = m_end_reg;
    assign m_range_error = m_rerr_reg;
    assign m_number_kind = m_kind_reg;
    assign pop           = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        logic signed [18:0] e_sum, lim;
        logic [27:0]  dx;
        logic [59:0]  dprod;
        logic [23:0]  dq;
        logic [27:0]  dr;
        logic [2:0]   m;
        logic [63:0]  hi;
        logic         up;
        logic [64:0]  hsum;
        logic [52:0]  mfrac;
        logic [10:0]  field;
        logic signed [15:0] fy;

        m = t2b_pkg::eff_mode(mode);
        e_sum = (head.exp_neg ? -19'(head.expl_exp) : 19'(head.expl_exp))
              + 19'(head.impl_exp);
        lim = (head.kind == t2b_pkg::KIND_DEC) ? 19'sd400 : 19'sd4096;
        // Quotient chunk by reciprocal multiplication, exact below 2^32.
        dx = {rem_reg, acc_reg[MW-1:MW-DIV_W]};
        dprod = 60'(dx) * 60'(RECIP10);
        dq = dprod[58:35];
        dr = dx - (28'(dq) << 3) - (28'(dq) << 1);
        hi = acc_reg[MW-1:32];
        up = 1'b0;
        hsum = 65'd0;
        mfrac = hi[63:11];
        fy = y_reg + 16'sd1023;
        field = fy[10:0];

        state_next = state_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        kind_next  = kind_reg;
        zero_next  = zero_reg;
        trunc_next = trunc_reg;
        sub_next   = sub_reg;
        end_next   = end_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_bits_next  = m_bits_reg;
        m_end_next   = m_end_reg;
        m_rerr_next  = m_rerr_reg;
        m_kind_next  = m_kind_reg;

        unique case (state_reg)
            // Take a record and set up the clamped total exponent.
            ST_IDLE: begin
                if (q_valid) begin
                    acc_next   = head.mant;
                    neg_next   = head.neg;
                    kind_next  = head.kind;
                    end_next   = head.end_off[OUT_W-1:0];
                    zero_next  = (head.mant == '0);
                    trunc_next = (head.kind == t2b_pkg::KIND_HEX) && head.sticky;
                    if (e_sum > lim) begin
                        e_sum = lim;
                    end else if (e_sum < -lim) begin
                        e_sum = -lim;
                    end
                    if ((head.kind != t2b_pkg::KIND_DEC && head.kind != t2b_pkg::KIND_HEX)
                        || head.mant == '0) begin
                        state_next = ST_PACK;
                    end else if (head.kind == t2b_pkg::KIND_HEX) begin
                        y_next = 16'(e_sum);
                        state_next = ST_PNORM;
                    end else begin
                        y_next = 16'sd0;
                        e_next = 14'(e_sum);
                        state_next = ST_SCALE;
                    end
                end
            end
            // Decimal scaling by ten, one multiply or renormalizing shift a cycle.
            ST_SCALE: begin
                if (e_reg > 14'sd0) begin
                    if (acc_reg[MW-1:MW-4] != 4'd0) begin
                        acc_next = acc_reg >> 1;
                        y_next = y_reg + 16'sd1;
                    end else begin
                        e_next = e_reg - 14'sd1;
                        acc_next = {acc_reg[MW-4:0], 3'b000} + {acc_reg[MW-2:0], 1'b0};
                    end
                end else if (e_reg < 14'sd0) begin
                    if (!acc_reg[MW-1]) begin
                        acc_next = acc_reg << 1;
                        y_next = y_reg - 16'sd1;
                    end else begin
                        e_next = e_reg + 14'sd1;
                        rem_next = 4'd0;
                        dcnt_next = 5'd0;
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_PNORM;
                end
            end
            // Divide by ten, 24 bits of quotient a cycle.
            ST_DIV: begin
                acc_next = {acc_reg[MW-DIV_W-1:0], dq};
                rem_next = dr[3:0];
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == DIV_LAST) begin
                    state_next = ST_SCALE;
                end
            end
            // Normalize so that the top bit is set.
            ST_PNORM: begin
                if (!acc_reg[MW-1]) begin
                    acc_next = acc_reg << 1;
                    y_next = y_reg - 16'sd1;
                end else begin
                    y_next = y_reg + 16'sd95;
                    sub_next = 1'b0;
                    state_next = ST_PSUB;
                end
            end
            // Denormalize below the smallest normal exponent.
            ST_PSUB: begin
                if (y_reg < MIN_EXP) begin
                    trunc_next = trunc_reg || acc_reg[0];
                    acc_next = acc_reg >> 1;
                    y_next = y_reg + 16'sd1;
                    sub_next = 1'b1;
                end else begin
                    if (sub_reg) begin
                        y_next = y_reg - 16'sd1;
                    end
                    state_next = ST_ROUND;
                end
            end
            // Round at bit 11 of the upper word.
            ST_ROUND: begin
                if (m == t2b_pkg::RM_NEAR_EVEN) begin
                    up = hi[10] && (trunc_reg || hi[11] || hi[9:0] != 10'd0
                        || acc_reg[31:0] != 32'd0);
                end else if (m == t2b_pkg::RM_NEAR_AWAY) begin
                    up = hi[10];
                end else if ((m == t2b_pkg::RM_DOWN && neg_reg)
                    || (m == t2b_pkg::RM_UP && !neg_reg)) begin
                    up = trunc_reg || hi[10:0] != 11'd0 || acc_reg[31:0] != 32'd0;
                end
                if (up) begin
                    hsum = {1'b0, hi} + 65'h800;
                    if (hsum[64]) begin
                        acc_next[MW-1:32] = 64'h8000000000000000;
                        y_next = y_reg + 16'sd1;
                    end else begin
                        acc_next[MW-1:32] = hsum[63:0];
                    end
                end
                state_next = ST_PACK;
            end
            // Pack the result into the output register once it is free.
            ST_PACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_end_next   = end_reg;
                    m_kind_next  = kind_reg;
                    m_rerr_next  = 1'b0;
                    if (kind_reg == t2b_pkg::KIND_INF) begin
                        m_bits_next = {neg_reg, 11'h7FF, 52'd0};
                    end else if (kind_reg == t2b_pkg::KIND_NAN) begin
                        m_bits_next = 64'h7FF8000000000000;
                    end else if (kind_reg != t2b_pkg::KIND_DEC
                        && kind_reg != t2b_pkg::KIND_HEX) begin
                        m_bits_next = 64'd0;
                    end else if (zero_reg) begin
                        m_bits_next = {neg_reg, 63'd0};
                    end else if (y_reg >= 16'sd1024) begin
                        m_bits_next = {neg_reg, 11'h7FF, 52'd0};
                        m_rerr_next = 1'b1;
                    end else begin
                        if (field == 11'd0 && mfrac[52]) begin
                            field = 11'd1;
                        end
                        m_rerr_next = (mfrac == 53'd0);
                        m_bits_next = {neg_reg, field, mfrac[51:0]};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        e_reg      <= e_next;
        y_reg      <= y_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        neg_reg    <= neg_next;
        kind_reg   <= kind_next;
        zero_reg   <= zero_next;
        trunc_reg  <= trunc_next;
        sub_reg    <= sub_next;
        end_reg    <= end_next;
        m_bits_reg <= m_bits_next;
        m_end_reg  <= m_end_next;
        m_rerr_reg <= m_rerr_next;
        m_kind_reg <= m_kind_next;
    end

endmodule

`default_nettype wire

// ===== sv/text_to_binary64_converter.sv =====
// Text to IEEE binary64 converter, top level.
// Instantiates t2b_front, t2b_queue and t2b_back; depends on t2b_pkg.
//
// The input channel carries one text byte per request (s_char_code) with
// s_last marking the final byte of a string. Each string yields exactly one
// result request on the m_ channel: binary64 bits, consumed length, a range
// flag and the number kind. cfg_wr_en/cfg_wr_data set the rounding mode.
// Bytes are parsed at one per cycle while s_ready is high. After the byte with
// s_last, s_ready is low while the parsed record is placed in a two-entry queue.
// The converter takes a record and works through: times-ten steps, each after
// up to four renormalizing shifts; divide-by-ten steps in 24-bit quotient
// chunks, each after left shifts that set the top bit; up to 95 normalizing
// shifts; one shift per bit of subnormal denormalization; then rounding and
// packing. Special kinds and zero go straight to packing.
// The parser keeps accepting bytes while the converter works; after an end of
// string it stalls until the record is placed, which waits while the queue is full. The result waits in the
// output register while m_ready is low, and the converter then holds.
// Reset clears the parser, the queue, the output valid and the rounding mode.
`default_nettype none

module text_to_binary64_converter #(
    parameter int MAX_CHARS  = 4096,
    parameter int DEC_DIGITS = 28
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_char_code,
    input  wire logic                              s_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [63:0]                            m_value_bits,
    output logic [$clog2(MAX_CHARS + 1)-1:0]       m_end_offset,
    output logic                                   m_range_error,
    output logic [2:0]                             m_number_kind
);

    localparam int OUT_W = $clog2(MAX_CHARS + 1);

    logic [2:0]        mode_reg;
    logic              push, q_full, pop, q_valid;
    t2b_pkg::num_rec_t rec, head;

    // Rounding mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= t2b_pkg::RM_NEAR_EVEN;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    t2b_front #(
        .MAX_CHARS  (MAX_CHARS),
        .DEC_DIGITS (DEC_DIGITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last      (s_last),
        .mode        (mode_reg),
        .push        (push),
        .q_full      (q_full),
        .rec         (rec)
    );

    t2b_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (rec),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid)
    );

    t2b_back #(
        .OUT_W (OUT_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .mode          (mode_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_bits  (m_value_bits),
        .m_end_offset  (m_end_offset),
        .m_range_error (m_range_error),
        .m_number_kind (m_number_kind)
    );

endmodule

`default_nettype wire

// ===== tb/sv/text_to_binary64_converter_tb.sv =====
// Testbench for text_to_binary64_converter: feeds number text byte by byte and
// checks every converted result against an in-bench predictor of the parser and converter.
// Depends on t2b_pkg and the converter RTL only.
`default_nettype none

module text_to_binary64_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_LIMIT = 4096;
    localparam int DEC_KEEP = 28;
    localparam int HEX_KEEP = 24;
    localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;
    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TOP_NIBBLE = 64'hF000_0000_0000_0000;
    localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

    typedef enum int {
        SCAN_WS, SCAN_LEAD, SCAN_INF, SCAN_INF_TAIL, SCAN_NAN, SCAN_NAN_OPEN,
        SCAN_NAN_TAG, SCAN_ZERO, SCAN_HEX_X, SCAN_HEX_DOT, SCAN_DOT_FIRST,
        SCAN_MANT, SCAN_EXP_MARK, SCAN_EXP_SIGN, SCAN_EXP_DIG, SCAN_DONE
    } scan_phase_e;

    typedef struct {
        logic [63:0] bits;
        logic [12:0] offset;
        logic        range_err;
        logic [2:0]  kind;
    } conv_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value_bits;
    logic [12:0] m_end_offset;
    logic        m_range_error;
    logic [2:0]  m_number_kind;

    // Predictor state: a copy of the parser and the rounding register.
    logic [2:0]  round_mode;
    scan_phase_e scan;
    bit          neg, hexm, point, exp_neg, sticky, round_pending;
    logic [63:0] acc_hi, acc_lo;
    int          digits, word_idx, impl_exp, expl_exp, char_cnt, commit_end;
    logic [2:0]  kind;

    string word_inf = "inf";
    string word_inity = "inity";
    string word_nan = "nan";

    conv_result_t pending_results[$];
    byte unsigned txt[$];
    int errors;
    int bytes_sent;
    int snd_idle, rcv_idle;

    text_to_binary64_converter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_bits  (m_value_bits),
        .m_end_offset  (m_end_offset),
        .m_range_error (m_range_error),
        .m_number_kind (m_number_kind)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- 96-bit accumulator helpers ----------------

    function automatic void acc_add(inout logic [63:0] hi, inout logic [63:0] lo,
                                    input logic [63:0] v);
        lo = lo + v;
        if (lo > LOW32) begin
            lo = lo & LOW32;
            hi = hi + 64'd1;
        end
    endfunction

    function automatic void acc_shl(inout logic [63:0] hi, inout logic [63:0] lo);
        hi = (hi << 1) | (lo >> 31);
        lo = (lo << 1) & LOW32;
    endfunction

    function automatic void acc_shr(inout logic [63:0] hi, inout logic [63:0] lo);
        lo = (lo >> 1) | ((hi & 64'd1) << 31);
        hi = hi >> 1;
    endfunction

    function automatic void acc_mul10(inout logic [63:0] hi, inout logic [63:0] lo);
        logic [63:0] t;
        t = lo * 64'd10;
        hi = hi * 64'd10 + (t >> 32);
        lo = t & LOW32;
    endfunction

    function automatic void acc_div10(inout logic [63:0] hi, inout logic [63:0] lo);
        logic [63:0] q;
        q = (((hi % 64'd10) << 32) | lo) / 64'd10;
        hi = hi / 64'd10;
        lo = 64'd0;
        acc_add(hi, lo, q);
    endfunction

    // ---------------- character classes ----------------

    function automatic int to_lower(int c);
        return (c >= "A" && c <= "Z") ? c + 32 : c;
    endfunction

    function automatic bit is_dec(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(int c);
        int l;
        l = to_lower(c);
        return is_dec(c) || (l >= "a" && l <= "f");
    endfunction

    function automatic int hex_value(int c);
        return is_dec(c) ? c - "0" : to_lower(c) - "a" + 10;
    endfunction

    function automatic logic [2:0] active_mode();
        return (round_mode > t2b_pkg::RM_NEAR_AWAY) ? t2b_pkg::RM_NEAR_EVEN : round_mode;
    endfunction

    // ---------------- parser predictor ----------------

    function automatic void clear_scan();
        scan = SCAN_WS;
        neg = 0; hexm = 0; point = 0; exp_neg = 0; sticky = 0; round_pending = 0;
        acc_hi = 64'd0; acc_lo = 64'd0;
        digits = 0; word_idx = 0; kind = t2b_pkg::KIND_NONE;
        impl_exp = 0; expl_exp = 0; char_cnt = 0; commit_end = 0;
    endfunction

    function automatic void bump_exp(int d);
        int v;
        v = impl_exp + d;
        if (v > 131071) v = 131071;
        if (v < -131071) v = -131071;
        impl_exp = v;
    endfunction

    function automatic void take_digit(int v);
        logic [2:0] m;
        if (digits == 0 && v == 0) begin
            if (point) bump_exp(hexm ? -4 : -1);
            return;
        end
        if (hexm) begin
            if (digits < HEX_KEEP) begin
                acc_hi = (acc_hi << 4) | (acc_lo >> 28);
                acc_lo = (acc_lo << 4) & LOW32;
                acc_add(acc_hi, acc_lo, v);
                digits++;
                if (point) bump_exp(-4);
            end else begin
                if (v != 0) sticky = 1;
                if (!point) bump_exp(4);
            end
            return;
        end
        if (digits < DEC_KEEP) begin
            acc_mul10(acc_hi, acc_lo);
            acc_add(acc_hi, acc_lo, v);
            digits++;
            if (point) bump_exp(-1);
            return;
        end
        if (!point) bump_exp(1);
        // The first dropped digit decides how later digits round.
        if (digits == DEC_KEEP) begin
            m = active_mode();
            digits++;
            if (m == t2b_pkg::RM_NEAR_EVEN) begin
                round_pending = (v >= 5);
                return;
            end
            if (m == t2b_pkg::RM_NEAR_AWAY) begin
                if (v >= 5) acc_add(acc_hi, acc_lo, 1);
            end else if ((m == t2b_pkg::RM_UP && !neg) || (m == t2b_pkg::RM_DOWN && neg)) begin
                round_pending = 1;
            end
        end
        if (round_pending && v != 0) begin
            acc_add(acc_hi, acc_lo, 1);
            round_pending = 0;
        end
    endfunction

    function automatic void take_exp_digit(int c);
        int v;
        v = expl_exp * 10 + (c - "0");
        expl_exp = (v > 8191) ? 8191 : v;
        commit_end = char_cnt;
        scan = SCAN_EXP_DIG;
    endfunction

    function automatic void scan_lead(int c);
        int l;
        l = to_lower(c);
        if (l == "i") begin
            scan = SCAN_INF; word_idx = 1;
        end else if (l == "n") begin
            scan = SCAN_NAN; word_idx = 1;
        end else if (c == "0") begin
            scan = SCAN_ZERO; kind = t2b_pkg::KIND_DEC; commit_end = char_cnt;
        end else if (is_dec(c)) begin
            scan = SCAN_MANT; kind = t2b_pkg::KIND_DEC; take_digit(c - "0");
            commit_end = char_cnt;
        end else if (c == ".") begin
            scan = SCAN_DOT_FIRST;
        end else begin
            scan = SCAN_DONE;
        end
    endfunction

    function automatic void scan_mant(int c);
        int l;
        l = to_lower(c);
        if (hexm ? is_hex(c) : is_dec(c)) begin
            take_digit(hexm ? hex_value(c) : c - "0");
            commit_end = char_cnt;
        end else if (c == ".") begin
            if (point) scan = SCAN_DONE;
            else begin
                point = 1;
                commit_end = char_cnt;
            end
        end else if (l == (hexm ? "p" : "e")) begin
            scan = SCAN_EXP_MARK;
        end else begin
            scan = SCAN_DONE;
        end
    endfunction

    function automatic void scan_char(int c);
        int l;
        l = to_lower(c);
        char_cnt++;
        case (scan)
            SCAN_WS: begin
                if (!(c == " " || (c >= 9 && c <= 13))) begin
                    if (c == "+") scan = SCAN_LEAD;
                    else if (c == "-") begin
                        neg = 1;
                        scan = SCAN_LEAD;
                    end else scan_lead(c);
                end
            end
            SCAN_LEAD: scan_lead(c);
            SCAN_INF: begin
                if (word_idx < 3 && l == word_inf[word_idx]) begin
                    word_idx++;
                    if (word_idx == 3) begin
                        kind = t2b_pkg::KIND_INF; commit_end = char_cnt;
                        scan = SCAN_INF_TAIL; word_idx = 0;
                    end
                end else scan = SCAN_DONE;
            end
            SCAN_INF_TAIL: begin
                if (word_idx < 5 && l == word_inity[word_idx]) begin
                    word_idx++;
                    if (word_idx == 5) begin
                        commit_end = char_cnt;
                        scan = SCAN_DONE;
                    end
                end else scan = SCAN_DONE;
            end
            SCAN_NAN: begin
                if (word_idx < 3 && l == word_nan[word_idx]) begin
                    word_idx++;
                    if (word_idx == 3) begin
                        kind = t2b_pkg::KIND_NAN; commit_end = char_cnt;
                        scan = SCAN_NAN_OPEN;
                    end
                end else scan = SCAN_DONE;
            end
            SCAN_NAN_OPEN: scan = (c == "(") ? SCAN_NAN_TAG : SCAN_DONE;
            SCAN_NAN_TAG: begin
                if (!(is_dec(c) || (l >= "a" && l <= "z") || c == "_")) begin
                    if (c == ")") commit_end = char_cnt;
                    scan = SCAN_DONE;
                end
            end
            SCAN_ZERO: begin
                if (l == "x") scan = SCAN_HEX_X;
                else begin
                    scan = SCAN_MANT;
                    scan_mant(c);
                end
            end
            SCAN_HEX_X, SCAN_HEX_DOT: begin
                if (is_hex(c)) begin
                    hexm = 1; kind = t2b_pkg::KIND_HEX;
                    if (scan == SCAN_HEX_DOT) point = 1;
                    scan = SCAN_MANT;
                    take_digit(hex_value(c));
                    commit_end = char_cnt;
                end else if (c == "." && scan == SCAN_HEX_X) scan = SCAN_HEX_DOT;
                else scan = SCAN_DONE;
            end
            SCAN_DOT_FIRST: begin
                if (is_dec(c)) begin
                    point = 1; kind = t2b_pkg::KIND_DEC; scan = SCAN_MANT;
                    take_digit(c - "0");
                    commit_end = char_cnt;
                end else scan = SCAN_DONE;
            end
            SCAN_MANT: scan_mant(c);
            SCAN_EXP_MARK: begin
                if (is_dec(c)) take_exp_digit(c);
                else if (c == "+" || c == "-") begin
                    exp_neg = (c == "-");
                    scan = SCAN_EXP_SIGN;
                end else scan = SCAN_DONE;
            end
            SCAN_EXP_SIGN, SCAN_EXP_DIG: begin
                if (is_dec(c)) take_exp_digit(c);
                else scan = SCAN_DONE;
            end
            default: scan = SCAN_DONE;
        endcase
    endfunction

    // ---------------- rounding and packing ----------------

    function automatic bit round_mant(inout logic [63:0] hi, input logic [63:0] lo,
                                      input bit trunc);
        logic [2:0]  m;
        logic [63:0] below54, below53;
        bit          up;
        m = active_mode();
        below54 = hi << 54;
        below53 = hi << 53;
        up = 0;
        if (m == t2b_pkg::RM_NEAR_EVEN)
            up = hi[10] && (trunc || hi[11] || below54 != 0 || lo != 0);
        else if (m == t2b_pkg::RM_NEAR_AWAY)
            up = hi[10];
        else if ((m == t2b_pkg::RM_DOWN && neg) || (m == t2b_pkg::RM_UP && !neg))
            up = trunc || below53 != 0 || lo != 0;
        if (!up) return 0;
        hi = hi + 64'd2048;
        if (hi < 64'd2048) begin
            hi = TOP_BIT;
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [63:0] pack_double(logic [63:0] hi, logic [63:0] lo,
                                                longint y, bit trunc, output bit rerr);
        logic [63:0] sign, m, field;
        rerr = 0;
        sign = neg ? TOP_BIT : 64'd0;
        while (!hi[63]) begin
            acc_shl(hi, lo);
            y--;
        end
        y += 95;
        // Denormalize into the subnormal range, keeping a sticky bit.
        if (y < -1022) begin
            while (y < -1022) begin
                trunc = trunc || lo[0];
                acc_shr(hi, lo);
                y++;
            end
            y--;
        end
        if (round_mant(hi, lo, trunc)) y++;
        if (y >= 1024) begin
            rerr = 1;
            return sign | INF_BITS;
        end
        m = hi >> 11;
        if (m == 0) rerr = 1;
        field = 64'(y + 1023);
        if (field == 0 && m[52]) field = 64'd1;
        return sign | (field << 52) | (m & FRAC_MASK);
    endfunction

    function automatic logic [63:0] convert_value(output bit rerr);
        logic [63:0] hi, lo;
        longint e, y, lim;
        hi = acc_hi;
        lo = acc_lo;
        y = 0;
        rerr = 0;
        if (kind == t2b_pkg::KIND_INF) return (neg ? TOP_BIT : 64'd0) | INF_BITS;
        if (kind == t2b_pkg::KIND_NAN) return QNAN_BITS;
        if (kind != t2b_pkg::KIND_DEC && kind != t2b_pkg::KIND_HEX) return 64'd0;
        e = longint'(exp_neg ? -expl_exp : expl_exp) + impl_exp;
        lim = (kind == t2b_pkg::KIND_DEC) ? 400 : 4096;
        if (e > lim) e = lim;
        if (e < -lim) e = -lim;
        if (hi == 0 && lo == 0) return neg ? TOP_BIT : 64'd0;
        if (kind == t2b_pkg::KIND_HEX) return pack_double(hi, lo, e, sticky, rerr);
        // Decimal scaling with renormalization around each step.
        while (e > 0) begin
            while ((hi & TOP_NIBBLE) != 0) begin
                acc_shr(hi, lo);
                y++;
            end
            e--;
            acc_mul10(hi, lo);
        end
        while (e < 0) begin
            while (!hi[63]) begin
                acc_shl(hi, lo);
                y--;
            end
            e++;
            acc_div10(hi, lo);
        end
        return pack_double(hi, lo, y, 0, rerr);
    endfunction

    // Advance the predictor by one accepted byte; a final byte yields a result.
    function automatic void predict_byte(int c, bit is_last);
        conv_result_t r;
        bit rerr;
        if (scan != SCAN_DONE) begin
            if (char_cnt >= TEXT_LIMIT) c = 0;
            scan_char(c);
        end
        if (!is_last) return;
        if (scan != SCAN_DONE) scan_char(0);
        r.bits = convert_value(rerr);
        r.offset = (kind != t2b_pkg::KIND_NONE) ? 13'(commit_end) : 13'd0;
        r.range_err = rerr;
        r.kind = kind;
        pending_results.push_back(r);
        clear_scan();
    endfunction

    // ---------------- stimulus side ----------------

    task automatic send_byte(byte unsigned c, bit is_last);
        while ($urandom_range(99) < snd_idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_char_code <= c;
        s_last <= is_last;
        do @(posedge aclk); while (!s_ready);
        predict_byte(c, is_last);
        bytes_sent++;
    endtask

    // Send the text buffer as one string; an empty buffer sends a lone zero byte.
    task automatic send_text();
        int n;
        n = txt.size();
        if (n == 0) send_byte(8'd0, 1'b1);
        for (int i = 0; i < n; i++) send_byte(txt[i], i == n - 1);
        txt.delete();
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_text();
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_round_mode(logic [2:0] m);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        round_mode = m;
    endtask

    // Push a string with random letter case.
    function automatic void put_word(string s);
        int c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(1)) c -= 32;
            txt.push_back(8'(c));
        end
    endfunction

    function automatic void put_digits(int n, bit hex);
        int v;
        for (int i = 0; i < n; i++) begin
            v = $urandom_range(hex ? 15 : 9);
            if (v < 10) txt.push_back(8'("0" + v));
            else txt.push_back(8'(($urandom_range(1) ? "a" : "A") + v - 10));
        end
    endfunction

    function automatic void put_exponent(string mark, int maxd);
        put_word(mark);
        case ($urandom_range(2))
            0: txt.push_back("+");
            1: txt.push_back("-");
            default: ;
        endcase
        put_digits(($urandom_range(99) < 5) ? $urandom_range(3, 5) : $urandom_range(1, maxd),
                   0);
    endfunction

    // Build one random number text, mostly well formed.
    function automatic void make_number();
        int form, n;
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 6);
            repeat (n) txt.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(2)) begin
            case ($urandom_range(3))
                0: txt.push_back(" ");
                1: txt.push_back(8'd9);
                2: txt.push_back(8'd10);
                default: txt.push_back(8'($urandom_range(11, 13)));
            endcase
        end
        case ($urandom_range(2))
            0: txt.push_back("+");
            1: txt.push_back("-");
            default: ;
        endcase
        form = $urandom_range(99);
        if (form < 50) begin
            if ($urandom_range(3) == 0) put_digits($urandom_range(1, 3), 0);
            put_digits($urandom_range(0, 31), 0);
            if ($urandom_range(1)) begin
                txt.push_back(".");
                put_digits($urandom_range(1, 12), 0);
            end else if (txt.size() == 0 || !is_dec(txt[txt.size() - 1])) begin
                put_digits(1, 0);
            end
            if ($urandom_range(99) < 45) put_exponent("e", 2);
        end else if (form < 80) begin
            put_word("0x");
            put_digits($urandom_range(0, 27), 1);
            if ($urandom_range(1)) begin
                txt.push_back(".");
                put_digits($urandom_range(0, 8), 1);
            end
            if ($urandom_range(99) < 60) put_exponent("p", 4);
        end else if (form < 88) begin
            case ($urandom_range(2))
                0: put_word("inf");
                1: put_word("infinity");
                default: put_word("infin");
            endcase
        end else if (form < 96) begin
            put_word("nan");
            if ($urandom_range(1)) begin
                txt.push_back("(");
                put_word("a_1z");
                if ($urandom_range(3) != 0) txt.push_back(")");
            end
        end else begin
            case ($urandom_range(4))
                0: put_word("0x");
                1: put_word("0x.");
                2: put_word("1e");
                3: put_word(".");
                default: put_word("7p-");
            endcase
        end
        if ($urandom_range(99) < 20) txt.push_back(8'($urandom_range(255)));
    endfunction

    // ---------------- result side ----------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        conv_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: bits %h kind %0d", m_value_bits, m_number_kind);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_value_bits !== e.bits) begin
                    $error("value_bits: expected %h, actual %h", e.bits, m_value_bits);
                    errors++;
                end
                if (m_end_offset !== e.offset) begin
                    $error("end_offset: expected %0d, actual %0d", e.offset, m_end_offset);
                    errors++;
                end
                if (m_range_error !== e.range_err) begin
                    $error("range_error: expected %0b, actual %0b", e.range_err,
                           m_range_error);
                    errors++;
                end
                if (m_number_kind !== e.kind) begin
                    $error("number_kind: expected %0d, actual %0d", e.kind, m_number_kind);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_forms();
        send_str("0");
        send_str("  -1.5e3");
        send_str("+.25");
        send_str("0x1.8p1");
        send_str("0x");
        send_str("0x.");
        send_str("1e");
        send_str("1e+");
        send_str("INF");
        send_str("-infinity");
        send_str("infin");
        send_str("nan");
        send_str("NaN(ab_1)");
        send_str("nan(x");
        send_str("1e9999");
        send_str("-1e-400");
        send_str("4.9e-324");
        send_str("2.2250738585072011e-308");
        send_str("1234567890123456789012345678951");
        send_str("0x1ffffffffffffffffffffffffff3p0");
        send_str("abc");
        send_str("");
        send_str("1.2.3");
        send_str("0x1p-1080");
        send_str("-0x1.fffffffffffffp1023");
        send_str("1.7976931348623159e308");
        // A zero byte ends the number; the bytes after it are ignored.
        txt = '{"1", "2", 8'd0, "3", "4"};
        send_text();
        txt = '{8'hFF};
        send_text();
    endtask

    task automatic test_rounding_modes();
        for (int m = 0; m < 8; m++) begin
            set_round_mode(3'(m));
            send_str("-0.1");
            send_str("-2.5");
            send_str("0x1.00000000000018p0");
        end
    endtask

    task automatic test_random_traffic(int snd, int rcv);
        int stop_at;
        set_round_mode(3'($urandom_range(7)));
        snd_idle = snd;
        rcv_idle = rcv;
        stop_at = bytes_sent + 95;
        while (bytes_sent < stop_at) begin
            make_number();
            send_text();
        end
    endtask

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 3'd0;
        s_valid = 1'b0;
        s_char_code = 8'd0;
        s_last = 1'b0;
        errors = 0;
        bytes_sent = 0;
        snd_idle = 13;
        rcv_idle = 49;
        round_mode = t2b_pkg::RM_NEAR_EVEN;
        clear_scan();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_forms();
        test_rounding_modes();
        test_random_traffic(13, 49);
        test_random_traffic(49, 13);
        test_random_traffic(0, 0);
        wait_idle();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
